/* src/sbmp_pkg.sv */
// ----------------------------------------------------------------------------
// sbmp_pkg
// Shared types and constants for the SNMP BER message parser.
// ----------------------------------------------------------------------------
package sbmp_pkg;

	localparam int NestDepth    = 4;
	localparam int CommunityMax = 32;
	localparam int OidMax       = 32;
	localparam int PositionBits = 16;
	localparam int LevelBits    = $clog2(NestDepth + 1);
	localparam int SlotBits     = (NestDepth > 1) ? $clog2(NestDepth) : 1;

	localparam logic [PositionBits-1:0] PosMax = {PositionBits{1'b1}};

	localparam logic [7:0] TagSequence = 8'h30;
	localparam logic [7:0] TagPduLow   = 8'hA0;
	localparam logic [7:0] TagPduBulk  = 8'hA5;
	localparam logic [7:0] TagInteger  = 8'h02;
	localparam logic [7:0] TagOctets   = 8'h04;
	localparam logic [7:0] TagOid      = 8'h06;
	localparam logic [7:0] LongForm    = 8'h80;
	localparam logic [7:0] LengthMask  = 8'h7F;

	typedef enum logic [1:0] {
		PH_TAG   = 2'd0,
		PH_LEN   = 2'd1,
		PH_LONG  = 2'd2,
		PH_VALUE = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		TG_NONE      = 3'd0,
		TG_VERSION   = 3'd1,
		TG_REQUEST   = 3'd2,
		TG_STATUS    = 3'd3,
		TG_ERRINDEX  = 3'd4,
		TG_MAXREP    = 3'd5,
		TG_NONREP    = 3'd6,
		TG_COMMUNITY = 3'd7
	} target_t;

	localparam logic [1:0] KindCommunity = 2'd0;
	localparam logic [1:0] KindOid       = 2'd1;
	localparam logic [1:0] KindSummary   = 2'd2;

	// Input request.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	// Result request.
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  byte_value;
		logic [5:0]  byte_index;
		logic [7:0]  version;
		logic [7:0]  pdu_tag;
		logic [31:0] req_id;
		logic [7:0]  err_status;
		logic [7:0]  err_index;
		logic [7:0]  max_reps;
		logic [7:0]  non_reps;
		logic        malformed;
		logic        run_end;
	} out_item_t;

	// Work passed from the decode front to the emit back.
	typedef struct packed {
		logic       has_byte;
		logic [1:0] byte_kind;
		logic [7:0] byte_value;
		logic [5:0] byte_index;
		logic       has_summary;
		logic [7:0]  version;
		logic [7:0]  pdu_tag;
		logic [31:0] req_id;
		logic [7:0]  err_status;
		logic [7:0]  err_index;
		logic [7:0]  max_reps;
		logic [7:0]  non_reps;
		logic        malformed;
	} job_t;

	localparam int QueueDepth = 4;
	localparam int QueueBits  = $clog2(QueueDepth);

endpackage

/* src/sbmp_stream_if.sv */
// ----------------------------------------------------------------------------
// sbmp_stream_if
// Valid/ready channel carrying one payload request.
// ----------------------------------------------------------------------------
interface sbmp_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* src/sbmp_decoder.sv */
// ----------------------------------------------------------------------------
// sbmp_decoder
// Front part: walks the BER stream one byte per cycle while step is high and emits work.
// ----------------------------------------------------------------------------
module sbmp_decoder
	import sbmp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  in_item_t   item,
	output logic       job_valid,
	output job_t       job
);

	logic [PositionBits-1:0] pos_q;
	phase_t                  phase_q;
	logic [7:0]              tag_q;
	logic [31:0]             lacc_q;
	logic [2:0]              lleft_q;
	logic [31:0]             vleft_q;
	target_t                 target_q;
	logic [5:0]              offset_q;
	logic [PositionBits-1:0] stack_q [NestDepth];
	logic [LevelBits-1:0]    level_q;
	logic                    ver_seen_q, comm_seen_q;
	logic [7:0]  ver_q, pdu_q, stat_q, eidx_q, maxr_q, nonr_q;
	logic [31:0] req_q;
	logic        bad_q, stop_q;

	// Next-state copies.
	logic [PositionBits-1:0] pos_d;
	phase_t                  phase_d;
	logic [7:0]              tag_d;
	logic [31:0]             lacc_d;
	logic [2:0]              lleft_d;
	logic [31:0]             vleft_d;
	target_t                 target_d;
	logic [5:0]              offset_d;
	logic [PositionBits-1:0] stack_d [NestDepth];
	logic [LevelBits-1:0]    level_d;
	logic                    ver_seen_d, comm_seen_d;
	logic [7:0]  ver_d, pdu_d, stat_d, eidx_d, maxr_d, nonr_d;
	logic [31:0] req_d;
	logic        bad_d, stop_d;

	logic        emit_byte;
	logic [1:0]  emit_kind;
	logic [5:0]  emit_idx;

	// Pops every level whose end has been reached; the stack is small and each
	// level is a single compare, popped from the top down.
	function automatic logic [LevelBits-1:0] pop_level(
		input logic [LevelBits-1:0]    lvl,
		input logic [PositionBits-1:0] stk [NestDepth],
		input logic [PositionBits:0]   p
	);
		logic [LevelBits-1:0] l;
		l = lvl;
		for (int i = NestDepth; i >= 1; i--) begin
			if (l == LevelBits'(i) && {1'b0, stk[i-1]} <= p)
				l = LevelBits'(i - 1);
		end
		return l;
	endfunction

	// Per-byte decode.
	always_comb begin
		logic [7:0]  b;
		logic [PositionBits:0] p;
		logic [32:0] endp;
		logic [32:0] limit;
		logic [31:0] len;
		logic        hdr;
		logic [LevelBits-1:0] top;
		target_t     rt;
		b = item.data_byte;
		pos_d = pos_q; phase_d = phase_q; tag_d = tag_q; lacc_d = lacc_q;
		lleft_d = lleft_q; vleft_d = vleft_q; target_d = target_q;
		offset_d = offset_q; stack_d = stack_q; level_d = level_q;
		ver_seen_d = ver_seen_q; comm_seen_d = comm_seen_q;
		ver_d = ver_q; pdu_d = pdu_q; stat_d = stat_q; eidx_d = eidx_q;
		maxr_d = maxr_q; nonr_d = nonr_q; req_d = req_q;
		bad_d = bad_q; stop_d = stop_q;
		emit_byte = 1'b0; emit_kind = KindCommunity; emit_idx = offset_q;
		hdr = 1'b0; len = '0; rt = TG_NONE;
		p = {1'b0, pos_q};
		endp = '0; limit = '0; top = '0;

		if (!stop_q) begin
			if (pos_q == PosMax) begin
				bad_d = 1'b1; stop_d = 1'b1;
			end else begin
				pos_d = pos_q + 1'b1;
				unique case (phase_q)
					PH_TAG: begin
						level_d = pop_level(level_q, stack_q, p);
						tag_d = b;
						phase_d = PH_LEN;
					end
					PH_LEN: begin
						if (b[7]) begin
							if ((b & LengthMask) > 8'd4) begin
								bad_d = 1'b1; stop_d = 1'b1;
							end else if ((b & LengthMask) == 8'd0) begin
								hdr = 1'b1; len = '0;
							end else begin
								lacc_d = '0;
								lleft_d = b[2:0];
								phase_d = PH_LONG;
							end
						end else begin
							hdr = 1'b1; len = {24'd0, b};
						end
					end
					PH_LONG: begin
						lacc_d = {lacc_q[23:0], b};
						lleft_d = lleft_q - 3'd1;
						if (lleft_q == 3'd1) begin
							hdr = 1'b1; len = lacc_d;
						end
					end
					PH_VALUE: begin
						unique case (target_q)
							TG_VERSION:  if (offset_q == 6'd0) ver_d = b;
							TG_REQUEST: begin
								case (offset_q)
									6'd0: req_d[31:24] = b;
									6'd1: req_d[23:16] = b;
									6'd2: req_d[15:8]  = b;
									6'd3: req_d[7:0]   = b;
									default: ;
								endcase
							end
							TG_STATUS:   if (offset_q == 6'd0) stat_d = b;
							TG_ERRINDEX: if (offset_q == 6'd0) eidx_d = b;
							TG_MAXREP:   if (offset_q == 6'd0) maxr_d = b;
							TG_NONREP:   if (offset_q == 6'd0) nonr_d = b;
							TG_COMMUNITY: begin
								emit_byte = 1'b1; emit_kind = KindCommunity;
							end
							TG_NONE: ;
							default: ;
						endcase
						if (tag_q == TagOid) begin
							emit_byte = 1'b1; emit_kind = KindOid;
						end
						if (offset_q != 6'd63) offset_d = offset_q + 6'd1;
						vleft_d = vleft_q - 32'd1;
						if (vleft_q == 32'd1) phase_d = PH_TAG;
					end
					default: ;
				endcase
			end
		end

		// Header complete: check bounds and open the element.
		if (hdr) begin
			endp = 33'(pos_q) + 33'd1 + 33'(len);
			limit = 33'(PosMax);
			if (level_q != '0) begin
				top = level_q - 1'b1;
				limit = 33'(stack_q[top[SlotBits-1:0]]);
			end
			phase_d = PH_TAG;
			if (endp > limit) begin
				bad_d = 1'b1; stop_d = 1'b1;
			end else begin
				offset_d = '0;
				target_d = TG_NONE;
				if (tag_q == TagSequence || (tag_q >= TagPduLow && tag_q <= TagPduBulk)) begin
					if (level_q >= LevelBits'(NestDepth)) begin
						bad_d = 1'b1; stop_d = 1'b1;
					end else begin
						if (tag_q >= TagPduLow) pdu_d = tag_q;
						stack_d[level_q[SlotBits-1:0]] = endp[PositionBits-1:0];
						level_d = level_q + 1'b1;
					end
				end else begin
					if (tag_q == TagInteger) begin
						if (!ver_seen_q) begin
							ver_seen_d = 1'b1; ver_d = '0; rt = TG_VERSION;
						end else if (pdu_q == TagPduBulk) begin
							if (req_q == '0) rt = TG_REQUEST;
							else if (maxr_q == '0) rt = TG_MAXREP;
							else if (nonr_q == '0) rt = TG_NONREP;
						end else if (len == 32'd4) rt = TG_REQUEST;
						else if (len == 32'd1 && stat_q == '0) rt = TG_STATUS;
						else if (len == 32'd1 && eidx_q == '0) rt = TG_ERRINDEX;
						target_d = rt;
						case (rt)
							TG_REQUEST:  req_d = '0;
							TG_STATUS:   stat_d = '0;
							TG_ERRINDEX: eidx_d = '0;
							TG_MAXREP:   maxr_d = '0;
							TG_NONREP:   nonr_d = '0;
							default: ;
						endcase
					end
					if (tag_q == TagOctets && !comm_seen_q && len > 32'(CommunityMax)) begin
						bad_d = 1'b1; stop_d = 1'b1;
					end else if (tag_q == TagOid && len > 32'(OidMax)) begin
						bad_d = 1'b1; stop_d = 1'b1;
					end else begin
						if (tag_q == TagOctets && !comm_seen_q) begin
							comm_seen_d = 1'b1; target_d = TG_COMMUNITY;
						end
						vleft_d = len;
						if (len != '0) phase_d = PH_VALUE;
					end
				end
			end
		end

		// End of datagram: truncation check.
		if (item.last_byte && !stop_d) begin
			if (phase_d != PH_TAG ||
			    pop_level(level_d, stack_d, {1'b0, pos_d}) != '0)
				bad_d = 1'b1;
		end
	end

	assign job_valid = step;
	always_comb begin
		job.has_byte    = emit_byte;
		job.byte_kind   = emit_kind;
		job.byte_value  = item.data_byte;
		job.byte_index  = emit_idx;
		job.has_summary = item.last_byte;
		job.version     = ver_d;
		job.pdu_tag     = pdu_d;
		job.req_id      = req_d;
		job.err_status  = stat_d;
		job.err_index   = eidx_d;
		job.max_reps    = maxr_d;
		job.non_reps    = nonr_d;
		job.malformed   = bad_d;
	end

	// State registers; the last byte returns everything to reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; phase_q <= PH_TAG; tag_q <= '0; lacc_q <= '0;
			lleft_q <= '0; vleft_q <= '0; target_q <= TG_NONE; offset_q <= '0;
			for (int i = 0; i < NestDepth; i++) stack_q[i] <= '0;
			level_q <= '0; ver_seen_q <= 1'b0; comm_seen_q <= 1'b0;
			ver_q <= '0; pdu_q <= '0; stat_q <= '0; eidx_q <= '0;
			maxr_q <= '0; nonr_q <= '0; req_q <= '0; bad_q <= 1'b0; stop_q <= 1'b0;
		end else if (step && item.last_byte) begin
			pos_q <= '0; phase_q <= PH_TAG; tag_q <= '0; lacc_q <= '0;
			lleft_q <= '0; vleft_q <= '0; target_q <= TG_NONE; offset_q <= '0;
			for (int i = 0; i < NestDepth; i++) stack_q[i] <= '0;
			level_q <= '0; ver_seen_q <= 1'b0; comm_seen_q <= 1'b0;
			ver_q <= '0; pdu_q <= '0; stat_q <= '0; eidx_q <= '0;
			maxr_q <= '0; nonr_q <= '0; req_q <= '0; bad_q <= 1'b0; stop_q <= 1'b0;
		end else if (step) begin
			pos_q <= pos_d; phase_q <= phase_d; tag_q <= tag_d; lacc_q <= lacc_d;
			lleft_q <= lleft_d; vleft_q <= vleft_d; target_q <= target_d;
			offset_q <= offset_d; stack_q <= stack_d; level_q <= level_d;
			ver_seen_q <= ver_seen_d; comm_seen_q <= comm_seen_d;
			ver_q <= ver_d; pdu_q <= pdu_d; stat_q <= stat_d; eidx_q <= eidx_d;
			maxr_q <= maxr_d; nonr_q <= nonr_d; req_q <= req_d;
			bad_q <= bad_d; stop_q <= stop_d;
		end
	end

endmodule

/* src/sbmp_queue.sv */
// ----------------------------------------------------------------------------
// sbmp_queue
// Short queue of work between decode front and emit back.
// ----------------------------------------------------------------------------
module sbmp_queue
	import sbmp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic can_push,
	output logic not_empty,
	output job_t head,
	input  logic pop
);

	job_t                 slot_q [QueueDepth];
	logic [QueueBits-1:0] wr_q, rd_q;
	logic [QueueBits:0]   count_q;

	assign can_push  = count_q != (QueueBits+1)'(QueueDepth);
	assign not_empty = count_q != '0;
	assign head      = slot_q[rd_q];

	// Payload storage.
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_job;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			count_q <= count_q + (QueueBits+1)'(push) - (QueueBits+1)'(pop);
		end
	end

endmodule

/* src/sbmp_emitter.sv */
// ----------------------------------------------------------------------------
// sbmp_emitter
// Back part: turns each job into zero, one or two result requests.
// ----------------------------------------------------------------------------
module sbmp_emitter
	import sbmp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	input  job_t job,
	output logic job_pop,
	sbmp_stream_if.source res
);

	logic      byte_done_q;
	logic      need_byte, need_sum, fire, second;
	out_item_t cur;

	assign need_byte = job.has_byte && !byte_done_q;
	assign need_sum  = job.has_summary;
	assign second    = need_byte && need_sum;
	assign res.valid = job_valid && (need_byte || need_sum);
	assign fire      = res.valid && res.ready;
	assign job_pop   = (job_valid && !(need_byte || need_sum)) || (fire && !second);

	// Result selection: byte result first, then summary.
	always_comb begin
		cur = '0;
		if (need_byte) begin
			cur.kind       = job.byte_kind;
			cur.byte_value = job.byte_value;
			cur.byte_index = job.byte_index;
			cur.run_end    = !need_sum;
		end else begin
			cur.kind       = KindSummary;
			cur.version    = job.version;
			cur.pdu_tag    = job.pdu_tag;
			cur.req_id     = job.req_id;
			cur.err_status = job.err_status;
			cur.err_index  = job.err_index;
			cur.max_reps   = job.max_reps;
			cur.non_reps   = job.non_reps;
			cur.malformed  = job.malformed;
			cur.run_end    = 1'b1;
		end
	end
	assign res.payload = cur;

	// Remembers that the byte half of a two-result job has gone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) byte_done_q <= 1'b0;
		else if (job_pop) byte_done_q <= 1'b0;
		else if (fire && second) byte_done_q <= 1'b1;
	end

endmodule

/* src/snmp_ber_message_parser.sv */
// ----------------------------------------------------------------------------
// snmp_ber_message_parser
// Decodes SNMP BER datagrams one byte per request into byte and summary results.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  in_ch   | sink      | data_byte, last_byte
//  out_ch  | source    | kind, byte_value, byte_index, summary fields, run_end
//
// One byte is taken each cycle while the four-entry work queue has room.
// Each accepted byte becomes one queue entry whose results are offered in order,
// at most one per cycle; a final datagram byte that is also a community or OID
// value byte gives two results, byte first. Entries without results offer none.
// Reset clears all parse state at once; so does the last byte of each datagram.
// Output stalls fill the queue, then back-pressure the input.
module snmp_ber_message_parser
	import sbmp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	sbmp_stream_if.sink   in_ch,
	sbmp_stream_if.source out_ch
);

	logic step, jv, can_push, q_ne, q_pop;
	job_t job, head;

	assign in_ch.ready = can_push;
	assign step = in_ch.valid && in_ch.ready;

	sbmp_decoder u_dec (
		.clk, .arst_n, .step, .item(in_ch.payload), .job_valid(jv), .job
	);

	sbmp_queue u_q (
		.clk, .arst_n, .push(jv), .push_job(job), .can_push,
		.not_empty(q_ne), .head, .pop(q_pop)
	);

	sbmp_emitter u_emit (
		.clk, .arst_n, .job_valid(q_ne), .job(head), .job_pop(q_pop), .res(out_ch)
	);

	// A result is only offered when work is queued.
	assert property (@(posedge clk) disable iff (!arst_n) out_ch.valid |-> q_ne)
		else $error("result without queued work");
	// Nothing is pushed into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) jv |-> can_push)
		else $error("queue overflow");
	// A summary result always ends its run.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.payload.kind == KindSummary) |-> out_ch.payload.run_end)
		else $error("summary without run end");

endmodule

/* tb/sbmp_checker.sv */
// ----------------------------------------------------------------------------
// sbmp_checker
// Watches both channels of the SNMP BER parser, predicts every result from the
// accepted bytes and compares each delivered result field by field.
// ----------------------------------------------------------------------------
module sbmp_checker
	import sbmp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  in_item_t    in_payload,
	input  logic        out_valid,
	input  logic        out_ready,
	input  out_item_t   out_payload,
	output int          fail_count,
	output int          pending_count
);

	// Decoder state mirrored from the block.
	logic [31:0] pos;
	phase_t      phase;
	logic [7:0]  tag;
	logic [31:0] len_acc;
	logic [2:0]  len_left;
	logic [31:0] val_left;
	target_t     target;
	logic [5:0]  offset;
	logic [31:0] ends [NestDepth];
	int          level;
	logic        ver_seen, comm_seen;
	logic [7:0]  ver_r, pdu_r, stat_r, eidx_r, maxrep_r, nonrep_r;
	logic [31:0] reqid_r;
	logic        bad, halted;

	out_item_t expected_results [$];

	assign pending_count = expected_results.size();

	task automatic clear_parser();
		pos = 0; phase = PH_TAG; tag = 0; len_acc = 0; len_left = 0; val_left = 0;
		target = TG_NONE; offset = 0;
		for (int i = 0; i < NestDepth; i++) ends[i] = 0;
		level = 0; ver_seen = 0; comm_seen = 0;
		ver_r = 0; pdu_r = 0; reqid_r = 0; stat_r = 0; eidx_r = 0;
		maxrep_r = 0; nonrep_r = 0; bad = 0; halted = 0;
	endtask

	task automatic mark_bad();
		bad = 1;
		halted = 1;
	endtask

	task automatic close_finished(input logic [31:0] p);
		while (level > 0 && ends[level-1] <= p) level--;
	endtask

	function automatic target_t integer_route(input logic [31:0] len);
		if (!ver_seen) return TG_VERSION;
		if (pdu_r == TagPduBulk) begin
			if (reqid_r == 0) return TG_REQUEST;
			if (maxrep_r == 0) return TG_MAXREP;
			if (nonrep_r == 0) return TG_NONREP;
			return TG_NONE;
		end
		if (len == 4) return TG_REQUEST;
		if (len == 1 && stat_r == 0) return TG_STATUS;
		if (len == 1 && eidx_r == 0) return TG_ERRINDEX;
		return TG_NONE;
	endfunction

	// Length known: bound check, nesting and field routing.
	task automatic open_element(input logic [31:0] len, input logic [31:0] start);
		logic [32:0] stop;
		logic [32:0] lim;
		stop = {1'b0, start} + len;
		lim = PosMax;
		if (level > 0) lim = ends[level-1];
		if (stop > lim) begin
			mark_bad();
			return;
		end
		offset = 0;
		target = TG_NONE;
		if (tag == TagSequence || (tag >= TagPduLow && tag <= TagPduBulk)) begin
			if (level >= NestDepth) begin
				mark_bad();
				return;
			end
			if (tag >= TagPduLow) pdu_r = tag;
			ends[level] = stop[31:0];
			level++;
			phase = PH_TAG;
			return;
		end
		if (tag == TagInteger) begin
			target = integer_route(len);
			if (target == TG_VERSION) begin
				ver_seen = 1;
				ver_r = 0;
			end
			case (target)
				TG_REQUEST:  reqid_r = 0;
				TG_STATUS:   stat_r = 0;
				TG_ERRINDEX: eidx_r = 0;
				TG_MAXREP:   maxrep_r = 0;
				TG_NONREP:   nonrep_r = 0;
				default: ;
			endcase
		end else if (tag == TagOctets) begin
			if (!comm_seen) begin
				if (len > CommunityMax) begin
					mark_bad();
					return;
				end
				comm_seen = 1;
				target = TG_COMMUNITY;
			end
		end else if (tag == TagOid) begin
			if (len > OidMax) begin
				mark_bad();
				return;
			end
		end
		val_left = len;
		phase = (len == 0) ? PH_TAG : PH_VALUE;
	endtask

	function automatic out_item_t byte_result(input logic [1:0] k, input logic [7:0] v,
			input logic [5:0] idx);
		out_item_t r;
		r = '0;
		r.kind = k;
		r.byte_value = v;
		r.byte_index = idx;
		return r;
	endfunction

	// Advance the decoder by one byte and queue the results it causes.
	task automatic parse_byte(input in_item_t it);
		out_item_t r;
		int        first;
		logic [31:0] p;
		first = expected_results.size();
		if (!halted) begin
			if (pos >= PosMax) begin
				mark_bad();
			end else begin
				p = pos;
				pos = p + 1;
				case (phase)
					PH_TAG: begin
						close_finished(p);
						tag = it.data_byte;
						phase = PH_LEN;
					end
					PH_LEN: begin
						if (it.data_byte & LongForm) begin
							if ((it.data_byte & LengthMask) > 4) mark_bad();
							else if ((it.data_byte & LengthMask) == 0) open_element(0, p + 1);
							else begin
								len_acc = 0;
								len_left = it.data_byte[2:0];
								phase = PH_LONG;
							end
						end else begin
							open_element(it.data_byte, p + 1);
						end
					end
					PH_LONG: begin
						len_acc = (len_acc << 8) | it.data_byte;
						if (len_left > 0) len_left--;
						if (len_left == 0) open_element(len_acc, p + 1);
					end
					default: begin
						case (target)
							TG_VERSION:  if (offset == 0) ver_r = it.data_byte;
							TG_REQUEST:
								if (offset < 4) reqid_r |= 32'(it.data_byte) << (24 - 8 * offset);
							TG_STATUS:   if (offset == 0) stat_r = it.data_byte;
							TG_ERRINDEX: if (offset == 0) eidx_r = it.data_byte;
							TG_MAXREP:   if (offset == 0) maxrep_r = it.data_byte;
							TG_NONREP:   if (offset == 0) nonrep_r = it.data_byte;
							TG_COMMUNITY:
								expected_results.push_back(
									byte_result(KindCommunity, it.data_byte, offset));
							default: ;
						endcase
						if (tag == TagOid)
							expected_results.push_back(byte_result(KindOid, it.data_byte, offset));
						if (offset < 63) offset++;
						if (val_left > 0) val_left--;
						if (val_left == 0) phase = PH_TAG;
					end
				endcase
			end
		end
		if (it.last_byte) begin
			if (!halted) begin
				close_finished(pos);
				if (phase != PH_TAG || level != 0) mark_bad();
			end
			r = '0;
			r.kind = KindSummary;
			r.version = ver_r;
			r.pdu_tag = pdu_r;
			r.req_id = reqid_r;
			r.err_status = stat_r;
			r.err_index = eidx_r;
			r.max_reps = maxrep_r;
			r.non_reps = nonrep_r;
			r.malformed = bad;
			expected_results.push_back(r);
			clear_parser();
		end
		if (expected_results.size() > first)
			expected_results[expected_results.size() - 1].run_end = 1;
	endtask

	task automatic compare_result(input out_item_t got);
		out_item_t w;
		if (expected_results.size() == 0) begin
			$error("unexpected result kind=%0d", got.kind);
			fail_count++;
			return;
		end
		w = expected_results.pop_front();
		if (w.kind != got.kind) begin
			$error("kind expected %0d actual %0d", w.kind, got.kind); fail_count++;
		end
		if (w.byte_value != got.byte_value) begin
			$error("byte_value expected %0h actual %0h", w.byte_value, got.byte_value);
			fail_count++;
		end
		if (w.byte_index != got.byte_index) begin
			$error("byte_index expected %0d actual %0d", w.byte_index, got.byte_index);
			fail_count++;
		end
		if (w.version != got.version) begin
			$error("version expected %0h actual %0h", w.version, got.version); fail_count++;
		end
		if (w.pdu_tag != got.pdu_tag) begin
			$error("pdu_tag expected %0h actual %0h", w.pdu_tag, got.pdu_tag); fail_count++;
		end
		if (w.req_id != got.req_id) begin
			$error("req_id expected %0h actual %0h", w.req_id, got.req_id);
			fail_count++;
		end
		if (w.err_status != got.err_status) begin
			$error("err_status expected %0h actual %0h", w.err_status, got.err_status);
			fail_count++;
		end
		if (w.err_index != got.err_index) begin
			$error("err_index expected %0h actual %0h", w.err_index, got.err_index);
			fail_count++;
		end
		if (w.max_reps != got.max_reps) begin
			$error("max_reps expected %0h actual %0h", w.max_reps, got.max_reps);
			fail_count++;
		end
		if (w.non_reps != got.non_reps) begin
			$error("non_reps expected %0h actual %0h", w.non_reps, got.non_reps);
			fail_count++;
		end
		if (w.malformed != got.malformed) begin
			$error("malformed expected %0d actual %0d", w.malformed, got.malformed);
			fail_count++;
		end
		if (w.run_end != got.run_end) begin
			$error("run_end expected %0d actual %0d", w.run_end, got.run_end); fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
		clear_parser();
	end

	// Predict on each accepted byte, then compare each accepted result.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			expected_results.delete();
		end else begin
			if (in_valid && in_ready) parse_byte(in_payload);
			if (out_valid && out_ready) compare_result(out_payload);
		end
	end

endmodule

/* tb/snmp_ber_message_parser_tb.sv */
// ----------------------------------------------------------------------------
// snmp_ber_message_parser_tb
// Feeds directed and random SNMP datagrams, well formed and broken, with
// random gaps and output stalls; the checker beside the parser gives the verdict.
// ----------------------------------------------------------------------------
module snmp_ber_message_parser_tb;
	import sbmp_pkg::*;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending_count;
	int   sent;
	logic stall_hold;
	int   out_wait;
	int   out_draw;

	sbmp_stream_if #(.payload_t(in_item_t))  in_ch ();
	sbmp_stream_if #(.payload_t(out_item_t)) out_ch ();

	snmp_ber_message_parser i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	sbmp_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_ch.valid),
		.in_ready      (in_ch.ready),
		.in_payload    (in_ch.payload),
		.out_valid     (out_ch.valid),
		.out_ready     (out_ch.ready),
		.out_payload   (out_ch.payload),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	// Datagram being assembled.
	logic [7:0] msg [$];

	// Valid stays high across back-to-back bytes and drops only for a gap.
	task automatic send_byte(input logic [7:0] b, input logic lst);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_ch.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.payload <= '{data_byte: b, last_byte: lst};
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sent++;
	endtask

	task automatic flush_msg();
		for (int i = 0; i < msg.size(); i++) send_byte(msg[i], i == msg.size() - 1);
		msg.delete();
		in_ch.valid <= 0;
		@(posedge clk);
	endtask

	task automatic add_tlv(input logic [7:0] t, input int n, input logic rnd);
		msg.push_back(t);
		msg.push_back(8'(n));
		for (int i = 0; i < n; i++) msg.push_back(rnd ? 8'($urandom) : 8'(i + 1));
	endtask

	// Builds a nested SNMP message with random content.
	task automatic build_snmp(input logic [7:0] pdu, input int oids);
		logic [7:0] body [$];
		logic [7:0] vb [$];
		int n;
		logic [7:0] tmp [$];
		msg.delete();
		for (int k = 0; k < oids; k++) begin
			n = $urandom_range(0, 12);
			vb.push_back(TagSequence); vb.push_back(8'(n + 4));
			vb.push_back(TagOid); vb.push_back(8'(n));
			for (int i = 0; i < n; i++) vb.push_back(8'($urandom));
			vb.push_back(8'h05); vb.push_back(8'h00);
		end
		add_tlv(TagInteger, $urandom_range(0, 5), 1);
		add_tlv(TagInteger, $urandom_range(0, 1), 1);
		add_tlv(TagInteger, 1, 1);
		tmp = msg; msg.delete();
		body = tmp;
		body.push_back(TagSequence); body.push_back(8'(vb.size()));
		foreach (vb[i]) body.push_back(vb[i]);
		msg.delete();
		add_tlv(TagInteger, 1, 1);
		add_tlv(TagOctets, $urandom_range(0, 10), 1);
		msg.push_back(pdu);
		if ($urandom_range(0, 1)) msg.push_back(8'(body.size()));
		else begin
			msg.push_back(8'h82); msg.push_back(0); msg.push_back(8'(body.size()));
		end
		foreach (body[i]) msg.push_back(body[i]);
		tmp = msg; msg.delete();
		msg.push_back(TagSequence); msg.push_back(8'(tmp.size()));
		foreach (tmp[i]) msg.push_back(tmp[i]);
	endtask

	// Random damage: byte flip, truncation or appended noise.
	task automatic damage_msg();
		int sel;
		sel = $urandom_range(0, 2);
		if (sel == 0) msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom);
		else if (sel == 1 && msg.size() > 2) msg = msg[0:$urandom_range(0, msg.size() - 2)];
		else repeat ($urandom_range(1, 4)) msg.push_back(8'($urandom));
	endtask

	// Output side: after each accepted result, wait a drawn number of cycles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 0;
			out_wait <= 0;
		end else if (out_ch.valid && out_ch.ready) begin
			if (stall_hold)
				out_draw = ($urandom_range(0, 12) == 0) ? $urandom_range(1, 12) : 0;
			else
				out_draw = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
			out_wait <= out_draw;
			out_ch.ready <= (out_draw == 0);
		end else if (out_wait > 0) begin
			out_wait <= out_wait - 1;
			out_ch.ready <= (out_wait == 1);
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	initial begin
		int wait_cycles;
		arst_n = 0;
		in_ch.valid = 0;
		in_ch.payload = '0;
		stall_hold = 0;
		sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: simple GET, bulk, empty values, long-form lengths and malformed cases.
		build_snmp(8'hA0, 2); flush_msg();
		build_snmp(TagPduBulk, 1); flush_msg();
		msg = '{8'h30, 8'h80}; flush_msg();
		msg = '{8'h30, 8'h85, 1, 2, 3, 4, 5}; flush_msg();
		msg = '{8'h30, 8'h05, 8'h02, 8'h84, 0, 0, 0}; flush_msg();
		msg = '{8'h06, 8'h21}; flush_msg();
		msg = '{8'h04, 8'h21}; flush_msg();
		msg = '{8'h30, 8'h0A, 8'h30, 8'h08, 8'h30, 8'h06, 8'hA1, 8'h04,
			8'h30, 8'h02, 8'h05, 8'h00}; flush_msg();
		msg = '{8'h30, 8'h02, 8'h02, 8'h05}; flush_msg();
		msg = '{8'hFF, 8'h00, 8'h00, 8'h7F}; flush_msg();
		msg = '{8'h04, 8'h00, 8'h04, 8'h01, 8'hAA, 8'h06, 8'h00}; flush_msg();
		msg = '{8'h02, 8'h01, 8'hFF, 8'h02, 8'h02, 8'h12, 8'h34}; flush_msg();

		// Drain before continuing.
		while (pending_count != 0) @(posedge clk);

		// Random datagrams.
		while (sent < 2000) begin
			case ($urandom_range(0, 9))
				0: begin
					repeat ($urandom_range(1, 20)) msg.push_back(8'($urandom));
				end
				1, 2: begin
					build_snmp(8'($urandom_range(TagPduLow, TagPduBulk)),
						$urandom_range(0, 3));
					damage_msg();
				end
				default: build_snmp(8'($urandom_range(TagPduLow, TagPduBulk)),
					$urandom_range(0, 4));
			endcase
			stall_hold = ($urandom_range(0, 4) == 0);
			flush_msg();
			if ($urandom_range(0, 20) == 0)
				while (pending_count != 0) @(posedge clk);
		end

		// Drain and settle.
		wait_cycles = 0;
		while (pending_count != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* files.f */
src/sbmp_pkg.sv
src/sbmp_stream_if.sv
src/sbmp_decoder.sv
src/sbmp_queue.sv
src/sbmp_emitter.sv
src/snmp_ber_message_parser.sv
tb/sbmp_checker.sv
tb/snmp_ber_message_parser_tb.sv
